### sv/jsu_pkg.sv
// Package for the JSON string unescaper: result event codes, the command
// record passed from front end to back end, and character/UTF-8 helpers.
// No dependencies.
package jsu_pkg;

  typedef enum logic [2:0] {
    EV_BYTE     = 3'd0,
    EV_DONE     = 3'd1,
    EV_BAD_HEX  = 3'd2,
    EV_BAD_CHAR = 3'd3,
    EV_BAD_SURR = 3'd4,
    EV_BAD_ESC  = 3'd5,
    EV_NO_QUOTE = 3'd6
  } event_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Surrogate halves, tested on the top six bits of a 16-bit code unit.
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;  // D800..DBFF
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;  // DC00..DFFF
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One command: up to four UTF-8 bytes of a code point, then an optional event.
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic        has_ev;
    event_e      ev;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } dec_t;

  function automatic dec_t hex_digit(input logic [7:0] c);
    dec_t r;
    r = '{ok: 1'b1, val: 8'h00};
    if (c inside {[8'h30:8'h39]}) begin
      r.val = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      r.val = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      r.val = c - 8'h37;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic dec_t short_escape(input logic [7:0] c);
    dec_t r;
    r = '{ok: 1'b1, val: 8'h00};
    case (c)
      CH_BSLASH: r.val = CH_BSLASH;
      CH_QUOTE:  r.val = CH_QUOTE;
      CH_SLASH:  r.val = CH_SLASH;
      8'h62:     r.val = 8'h08;  // b
      8'h66:     r.val = 8'h0C;  // f
      8'h6E:     r.val = 8'h0A;  // n
      8'h72:     r.val = 8'h0D;  // r
      8'h74:     r.val = 8'h09;  // t
      default:   r.ok  = 1'b0;
    endcase
    return r;
  endfunction

  // Byte idx (0 = lead) of the nbytes-long UTF-8 form of cp. A one-byte
  // form passes cp[7:0] unchanged, which also covers raw bytes 80..FF.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                           input logic [2:0] nbytes,
                                           input logic [2:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (nbytes)
      3'd2: begin
        case (idx)
          3'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx)
          3'd0:    b = {4'b1110, cp[15:12]};
          3'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          3'd0:    b = {5'b11110, cp[20:18]};
          3'd1:    b = {2'b10, cp[17:12]};
          3'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

### sv/jsu_text_if.sv
// Input channel of the JSON string unescaper: one raw text byte per transaction.
// No dependencies.
interface jsu_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

### sv/jsu_res_if.sv
// Output channel of the JSON string unescaper: one decoded result per transaction.
// No dependencies.
interface jsu_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] event_res;
  logic       last;

  modport source (output valid, output out_byte, output event_res, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input event_res, input last,
                  output ready);
endinterface

### sv/jsu_front.sv
// Front end of the unescaper: accepts text bytes, runs the string parser and
// turns each byte into at most one command. Depends on jsu_pkg, jsu_text_if.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsu_text_if.sink      text_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_STR     = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX     = 3'd3,
    PH_PAIR_BS = 3'd4,
    PH_PAIR_U  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [9:0]  high_q, high_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pair_q, pair_d;
  logic        accept;
  logic        ended;
  cmd_t        cmd;
  dec_t        dig;
  dec_t        esc;
  logic [7:0]  c;
  logic [15:0] hex_new;

  assign text_i.ready = !q_full_i;
  assign accept       = text_i.valid && !q_full_i;
  assign c            = text_i.text_byte;
  assign dig          = hex_digit(c);
  assign esc          = short_escape(c);
  assign hex_new      = {hex_q[11:0], dig.val[3:0]};

  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    high_d  = high_q;
    cnt_d   = cnt_q;
    pair_d  = pair_q;
    ended   = 1'b0;
    cmd     = '{cp: '0, nbytes: 3'd0, has_ev: 1'b0, ev: EV_BYTE};

    case (phase_q)
      PH_IDLE: begin
        phase_d = PH_STR;  // any byte counts as the opening quote
      end
      PH_STR: begin
        if (c == CH_QUOTE) begin
          ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_DONE;
        end else if (c == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else if (c < CH_SPACE) begin
          ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_CHAR;
        end else begin
          cmd.cp = {13'd0, c}; cmd.nbytes = 3'd1;
        end
      end
      PH_ESC: begin
        if (c == CH_U) begin
          phase_d = PH_HEX; hex_d = '0; cnt_d = '0; pair_d = 1'b0;
        end else if (esc.ok) begin
          cmd.cp = {13'd0, esc.val}; cmd.nbytes = 3'd1;
          phase_d = PH_STR;
        end else begin
          ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_ESC;
        end
      end
      PH_HEX: begin
        if (!dig.ok) begin
          ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_HEX;
        end else begin
          hex_d = hex_new;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (pair_q) begin
              if (hex_new[15:10] != SURR_LOW_TAG) begin
                ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_SURR;
              end else begin
                cmd.cp     = {1'b0, high_q, hex_new[9:0]} + SUPP_BASE;
                cmd.nbytes = 3'd4;
                pair_d     = 1'b0;
                phase_d    = PH_STR;
              end
            end else if (hex_new < 16'(CH_SPACE)) begin
              ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_CHAR;
            end else if (hex_new[15:10] == SURR_HIGH_TAG) begin
              high_d  = hex_new[9:0];
              phase_d = PH_PAIR_BS;
            end else begin
              cmd.cp = {5'd0, hex_new};
              if (hex_new < 16'h0080) begin
                cmd.nbytes = 3'd1;
              end else if (hex_new < 16'h0800) begin
                cmd.nbytes = 3'd2;
              end else begin
                cmd.nbytes = 3'd3;
              end
              phase_d = PH_STR;
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (c == CH_BSLASH) begin
          phase_d = PH_PAIR_U;
        end else begin
          ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_SURR;
        end
      end
      PH_PAIR_U: begin
        if (c == CH_U) begin
          phase_d = PH_HEX; hex_d = '0; cnt_d = '0; pair_d = 1'b1;
        end else begin
          ended = 1'b1; cmd.has_ev = 1'b1; cmd.ev = EV_BAD_SURR;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // Text ran out in the middle of a string: report by where it stopped.
    if (text_i.text_end && !ended && phase_d != PH_IDLE) begin
      cmd.has_ev = 1'b1;
      case (phase_d)
        PH_ESC:                cmd.ev = EV_BAD_ESC;
        PH_HEX:                cmd.ev = EV_BAD_HEX;
        PH_PAIR_BS, PH_PAIR_U: cmd.ev = EV_BAD_SURR;
        default:               cmd.ev = EV_NO_QUOTE;
      endcase
      ended = 1'b1;
    end

    if (ended) begin
      phase_d = PH_IDLE;
      pair_d  = 1'b0;
      cnt_d   = '0;
    end
  end

  assign push_o = accept && (cmd.nbytes != 3'd0 || cmd.has_ev);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hex_q   <= '0;
      high_q  <= '0;
      cnt_q   <= '0;
      pair_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      high_q  <= high_d;
      cnt_q   <= cnt_d;
      pair_q  <= pair_d;
    end
  end

endmodule

### sv/jsu_fifo.sv
// Command queue between front and back end of the unescaper.
// Depends on jsu_pkg.
module jsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::cmd_t head_o
);
  import jsu_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/jsu_back.sv
// Back end of the unescaper: expands each command into UTF-8 bytes and an
// optional event, one registered result per cycle unless stalled. Depends on jsu_pkg.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  jsu_pkg::cmd_t head_i,
  output logic          pop_o,
  jsu_res_if.source     res_o
);
  import jsu_pkg::*;

  logic [2:0] idx_q;
  logic [2:0] total;
  logic       load;
  logic       is_last;
  logic       valid_q;
  logic [7:0] byte_q;
  event_e     ev_q;
  logic       last_q;

  assign total   = head_i.nbytes + {2'b00, head_i.has_ev};
  assign is_last = (idx_q == total - 3'd1);
  assign load    = !q_empty_i && (!valid_q || res_o.ready);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= is_last;
      if (idx_q < head_i.nbytes) begin
        byte_q <= utf8_byte(head_i.cp, head_i.nbytes, idx_q);
        ev_q   <= EV_BYTE;
      end else begin
        byte_q <= 8'h00;
        ev_q   <= head_i.ev;
      end
    end
  end

  assign res_o.valid     = valid_q;
  assign res_o.out_byte  = byte_q;
  assign res_o.event_res = ev_q;
  assign res_o.last      = last_q;

endmodule

### sv/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output. Feed the raw bytes of one JSON
// string literal on text_i, the opening quote first; the block drops that
// first byte, copies plain bytes (0x80..0xFF included) unchanged, decodes the
// eight short escapes, and turns \uXXXX escapes and surrogate pairs into one
// to four UTF-8 bytes. Each result on res_o carries out_byte, an event code
// (byte, done, or one of five errors that end the string) and last, which
// marks the final result caused by one input byte; a byte that only advances
// the parser gives no result. Assert text_end with the final byte of the text;
// an unfinished string then ends with an error chosen by where it stopped.
// Rate: the front end takes one text byte per cycle whenever the four-entry
// command queue has room, so plain text streams at one byte per cycle while
// the receiver keeps up. The back end delivers one result per cycle through
// its output register while the receiver is ready, so a byte that yields
// several results holds the back end until all are out (up to five for a
// supplementary code point with an ending event); the queue absorbs such
// bursts. A byte's first result goes through the queue and output register.
// Depends on jsu_pkg, jsu_text_if, jsu_res_if, jsu_front, jsu_fifo, jsu_back.
module json_string_unescape_utf8 (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_text_if.sink  text_i,
  jsu_res_if.source res_o
);
  import jsu_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_cmd, head_cmd;

  // Parse and classify: one command per byte that has anything to report.
  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Decouple parsing from result delivery.
  jsu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_cmd)
  );

  // Expand commands into UTF-8 bytes and events.
  jsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .head_i    (head_cmd),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

### sv/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8.
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_byte_i,
  input logic [2:0] res_event_i,
  input logic       res_last_i
);
  import jsu_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_byte_i) &&
      $stable(res_event_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  // An ending event is always the final result of its input byte.
  a_ev_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_event_i != EV_BYTE |-> res_last_i)
    else $error("event not marked last");

  // Event results carry a zero byte.
  a_ev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_event_i != EV_BYTE |-> res_byte_i == 8'h00)
    else $error("event with nonzero byte");

  // Code 7 is never produced.
  a_ev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_event_i != 3'd7)
    else $error("undefined event code");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_byte_i  (res_o.out_byte),
  .res_event_i (res_o.event_res),
  .res_last_i  (res_o.last)
);

### tb/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescape_utf8: drives raw string bytes
// and checks every decoded result against typed table rows or a parser predictor.
// Depends on jsu_pkg, jsu_text_if, jsu_res_if and the block itself.
module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int StallLimit = 4000;
  // Length of the one long receiver hold-off.
  localparam int HoldCycles = 250;
  // Random text bytes to send after the directed table.
  localparam int RandItems  = 185;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_text_if text_if ();
  jsu_res_if  res_if ();

  json_string_unescape_utf8 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One decoded result as the receiver sees it.
  typedef struct {
    logic [7:0] ob;
    event_e     ev;
    logic       lst;
  } dec_res_t;

  // One raw text byte with its end-of-text flag.
  typedef struct {
    logic [7:0] b;
    logic       e;
  } text_item_t;

  // One row of the directed table. A row marked typed carries its own result
  // (none, or exactly one); every other row is checked against the predictor.
  typedef struct {
    logic [7:0] b;
    logic       e;
    bit         typed;
    bit         has_res;
    logic [7:0] ob;
    event_e     ev;
  } dir_row_t;

  // Parser phases, kept apart from the block's own encoding.
  typedef enum logic [2:0] {
    PH_IDLE, PH_STR, PH_ESC, PH_HEX, PH_PAIR_BS, PH_PAIR_U
  } parse_phase_e;

  dec_res_t   want_q[$];   // decoded results still to arrive, oldest first
  dec_res_t   burst_q[$];  // results caused by the byte just accepted
  text_item_t str_q[$];    // bytes of the string being generated
  dir_row_t   dir_tab[$];

  // Predictor state.
  parse_phase_e ph      = PH_IDLE;
  logic [15:0]  hexv    = '0;
  logic [9:0]   hi_part = '0;
  logic [1:0]   ndig    = '0;
  logic         pair_lo = 1'b0;

  int mismatch_cnt = 0;
  int res_seen     = 0;
  int rnd_sent     = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;  // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;       // 0..9
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;  // a..f
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;  // A..F
    return -1;
  endfunction

  function automatic int esc_val(input logic [7:0] c);
    case (c)
      CH_BSLASH: return int'(CH_BSLASH);
      CH_QUOTE:  return int'(CH_QUOTE);
      CH_SLASH:  return int'(CH_SLASH);
      8'h62:     return 8'h08;  // b
      8'h66:     return 8'h0C;  // f
      8'h6E:     return 8'h0A;  // n
      8'h72:     return 8'h0D;  // r
      8'h74:     return 8'h09;  // t
      default:   return -1;
    endcase
  endfunction

  task automatic put_res(input logic [7:0] b, input event_e code);
    dec_res_t r;
    r.ob  = b;
    r.ev  = code;
    r.lst = 1'b0;
    burst_q.push_back(r);
  endtask

  // Any ending event drops the parser back to idle.
  task automatic close_str(input event_e code);
    ph      = PH_IDLE;
    pair_lo = 1'b0;
    ndig    = '0;
    put_res(8'h00, code);
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_res(cp[7:0], EV_BYTE);
    end else if (cp < 21'h800) begin
      put_res({3'b110, cp[10:6]}, EV_BYTE);
      put_res({2'b10, cp[5:0]}, EV_BYTE);
    end else if (cp < 21'h10000) begin
      put_res({4'b1110, cp[15:12]}, EV_BYTE);
      put_res({2'b10, cp[11:6]}, EV_BYTE);
      put_res({2'b10, cp[5:0]}, EV_BYTE);
    end else begin
      put_res({5'b11110, cp[20:18]}, EV_BYTE);
      put_res({2'b10, cp[17:12]}, EV_BYTE);
      put_res({2'b10, cp[11:6]}, EV_BYTE);
      put_res({2'b10, cp[5:0]}, EV_BYTE);
    end
  endtask

  // Advance the predicted parser by one accepted byte; results land in burst_q.
  task automatic unescape_step(input logic [7:0] c, input logic e);
    int     d;
    logic   ended;
    event_e code;
    burst_q.delete();
    ended = 1'b0;
    case (ph)
      PH_IDLE: begin
        // Whatever it is, the first byte stands for the opening quote.
        ph = PH_STR;
      end
      PH_STR: begin
        if (c == CH_QUOTE) begin
          close_str(EV_DONE);
          ended = 1'b1;
        end else if (c == CH_BSLASH) begin
          ph = PH_ESC;
        end else if (c < CH_SPACE) begin
          close_str(EV_BAD_CHAR);
          ended = 1'b1;
        end else begin
          put_res(c, EV_BYTE);
        end
      end
      PH_ESC: begin
        d = esc_val(c);
        if (c == CH_U) begin
          ph      = PH_HEX;
          hexv    = '0;
          ndig    = '0;
          pair_lo = 1'b0;
        end else if (d >= 0) begin
          put_res(d[7:0], EV_BYTE);
          ph = PH_STR;
        end else begin
          close_str(EV_BAD_ESC);
          ended = 1'b1;
        end
      end
      PH_HEX: begin
        d = hex_val(c);
        if (d < 0) begin
          close_str(EV_BAD_HEX);
          ended = 1'b1;
        end else begin
          hexv = {hexv[11:0], d[3:0]};
          ndig = ndig + 2'd1;
          if (ndig == 2'd0) begin
            if (pair_lo) begin
              // Low half of a pair: only the range is checked, not the control limit.
              if (hexv < 16'hDC00 || hexv > 16'hDFFF) begin
                close_str(EV_BAD_SURR);
                ended = 1'b1;
              end else begin
                put_utf8({1'b0, hi_part, hexv[9:0]} + 21'h10000);
                pair_lo = 1'b0;
                ph      = PH_STR;
              end
            end else if (hexv < 16'h0020) begin
              close_str(EV_BAD_CHAR);
              ended = 1'b1;
            end else if (hexv >= 16'hD800 && hexv <= 16'hDBFF) begin
              hi_part = hexv[9:0];
              ph      = PH_PAIR_BS;
            end else begin
              // A lone low surrogate lands here too and is encoded as is.
              put_utf8({5'b0, hexv});
              ph = PH_STR;
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (c == CH_BSLASH) begin
          ph = PH_PAIR_U;
        end else begin
          close_str(EV_BAD_SURR);
          ended = 1'b1;
        end
      end
      PH_PAIR_U: begin
        if (c == CH_U) begin
          ph      = PH_HEX;
          hexv    = '0;
          ndig    = '0;
          pair_lo = 1'b1;
        end else begin
          close_str(EV_BAD_SURR);
          ended = 1'b1;
        end
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase
    // Text ran out before the string finished: the event tells where it stopped.
    if (e && !ended && ph != PH_IDLE) begin
      case (ph)
        PH_ESC:                code = EV_BAD_ESC;
        PH_HEX:                code = EV_BAD_HEX;
        PH_PAIR_BS, PH_PAIR_U: code = EV_BAD_SURR;
        default:               code = EV_NO_QUOTE;
      endcase
      close_str(code);
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].lst = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the block takes it, then record what it
  // should produce: the typed result for typed table rows, else the prediction.
  task automatic send_text(input logic [7:0] b, input logic e, input bit typed,
                           input bit has_res, input logic [7:0] ob, input event_e ev);
    dec_res_t r;
    while (!calm && $urandom_range(99) < 15) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    text_if.text_end  <= e;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    unescape_step(b, e);
    if (typed) begin
      if (has_res) begin
        r.ob  = ob;
        r.ev  = ev;
        r.lst = 1'b1;
        want_q.push_back(r);
      end
    end else begin
      foreach (burst_q[i]) want_q.push_back(burst_q[i]);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic e, input bit typed,
                         input bit has_res, input logic [7:0] ob, input event_e ev);
    dir_row_t row;
    row.b       = b;
    row.e       = e;
    row.typed   = typed;
    row.has_res = has_res;
    row.ob      = ob;
    row.ev      = ev;
    dir_tab.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Random string generation
  // ---------------------------------------------------------------------------

  // Append a byte; now and then flag the text as ending mid-string.
  task automatic push_txt(input logic [7:0] b);
    text_item_t t;
    t.b = b;
    t.e = ($urandom_range(49) == 0);
    str_q.push_back(t);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic push_hex(input logic [15:0] v, input int ndigits);
    for (int i = 0; i < ndigits; i++) push_txt(hex_char(v[15 - 4 * i -: 4]));
  endtask

  task automatic push_u(input logic [15:0] v);
    push_txt(CH_BSLASH);
    push_txt(CH_U);
    push_hex(v, 4);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom_range(255, 32));
    if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h61;
    return b;
  endfunction

  function automatic logic [7:0] esc_letter(input int i);
    case (i)
      0:       return CH_BSLASH;
      1:       return CH_QUOTE;
      2:       return CH_SLASH;
      3:       return 8'h62;
      4:       return 8'h66;
      5:       return 8'h6E;
      6:       return 8'h72;
      default: return 8'h74;
    endcase
  endfunction

  function automatic logic [15:0] bmp_value();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(16'h7F, 16'h20));
      1:       return 16'($urandom_range(16'h7FF, 16'h80));
      2:       return 16'($urandom_range(16'hD7FF, 16'h800));
      default: return 16'($urandom_range(16'hFFFF, 16'hE000));
    endcase
  endfunction

  // Build one string into str_q: mostly well-formed tokens with random content,
  // with a minority of faults that end the string early.
  task automatic build_string();
    int         ntok;
    int         kind;
    int         k;
    logic [7:0] b;
    str_q.delete();
    push_txt(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CH_QUOTE);
    ntok = $urandom_range(8);
    repeat (ntok) begin
      kind = $urandom_range(99);
      if (kind < 40 || kind >= 87) begin
        push_txt(plain_char());
      end else if (kind < 52) begin
        push_txt(CH_BSLASH);
        push_txt(esc_letter($urandom_range(7)));
      end else if (kind < 62) begin
        push_u(bmp_value());
      end else if (kind < 70) begin
        push_u(16'hD800 + 16'($urandom_range(16'h3FF)));
        push_u(16'hDC00 + 16'($urandom_range(16'h3FF)));
      end else if (kind < 74) begin
        push_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
      end else if (kind < 77) begin
        // Raw control byte.
        push_txt(8'($urandom_range(31)));
        return;
      end else if (kind < 79) begin
        // Unknown escape letter.
        b = 8'($urandom_range(255));
        if (esc_val(b) >= 0 || b == CH_U) b = 8'h78;
        push_txt(CH_BSLASH);
        push_txt(b);
        return;
      end else if (kind < 81) begin
        // Non-hex byte among the digits.
        push_txt(CH_BSLASH);
        push_txt(CH_U);
        push_hex(16'($urandom()), $urandom_range(3));
        b = 8'($urandom_range(255));
        if (hex_val(b) >= 0) b = 8'h67;
        push_txt(b);
        return;
      end else if (kind < 83) begin
        // Escaped control code.
        push_u(16'($urandom_range(31)));
        return;
      end else if (kind < 85) begin
        // High surrogate without a proper low half.
        push_u(16'($urandom_range(16'hDBFF, 16'hD800)));
        case ($urandom_range(2))
          0: begin
            b = 8'($urandom_range(255));
            if (b == CH_BSLASH) b = 8'h78;
            push_txt(b);
          end
          1: begin
            b = 8'($urandom_range(255));
            if (b == CH_U) b = 8'h78;
            push_txt(CH_BSLASH);
            push_txt(b);
          end
          default: begin
            if ($urandom_range(1)) push_u(16'($urandom_range(16'hDBFF)));
            else push_u(16'($urandom_range(16'hFFFF, 16'hE000)));
          end
        endcase
        return;
      end else begin
        // Text cut short inside an escape.
        k = $urandom_range(2);
        push_txt(CH_BSLASH);
        if (k == 1) begin
          push_txt(CH_U);
          push_hex(16'($urandom()), $urandom_range(3));
        end else if (k == 2) begin
          push_txt(CH_U);
          push_hex(16'($urandom_range(16'hDBFF, 16'hD800)), 4);
          if ($urandom_range(1)) push_txt(CH_BSLASH);
        end
        str_q[str_q.size() - 1].e = 1'b1;
        return;
      end
    end
    if ($urandom_range(99) < 85) begin
      push_txt(CH_QUOTE);
      if ($urandom_range(3) == 0) str_q[str_q.size() - 1].e = 1'b1;
    end else begin
      str_q[str_q.size() - 1].e = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // Receiver: random stalls, one long hold-off once the random part is
  // under way so that the queue fills and the input stalls.
  initial begin
    bit held;
    held         = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && rnd_sent >= 50) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      res_if.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0h want %0h", res_seen, what, got, want);
    mismatch_cnt++;
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    dec_res_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (want_q.size() == 0) begin
        flag_mismatch("unexpected result, event", int'(res_if.event_res), 0);
      end else begin
        w = want_q.pop_front();
        if (res_if.out_byte !== w.ob) flag_mismatch("out_byte", res_if.out_byte, w.ob);
        if (res_if.event_res !== w.ev) flag_mismatch("event_res", res_if.event_res, w.ev);
        if (res_if.last !== w.lst) flag_mismatch("last", res_if.last, w.lst);
      end
      res_seen++;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles, %0d results pending",
               quiet_cycles, want_q.size());
      $display("json_string_unescape_utf8_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    text_if.valid     = 1'b0;
    text_if.text_byte = 8'h00;
    text_if.text_end  = 1'b0;
    rst_ni            = 1'b0;

    // String one: any byte opens, edge plain bytes, a lone low surrogate,
    // the largest code point as a pair, its high half in lower-case digits, then done.
    add_row(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h20, 1'b0, 1'b1, 1'b1, 8'h20, EV_BYTE);
    add_row(8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, EV_BYTE);
    add_row(CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(CH_U, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h44, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // D
    add_row(8'h43, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // C
    add_row(8'h30, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h30, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(CH_U, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h64, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // d
    add_row(8'h62, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // b
    add_row(8'h66, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // f
    add_row(8'h66, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // f
    add_row(CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(CH_U, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h44, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // D
    add_row(8'h46, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // F
    add_row(8'h46, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // F
    add_row(8'h46, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);  // F
    add_row(CH_QUOTE, 1'b0, 1'b1, 1'b1, 8'h00, EV_DONE);
    // Raw control byte.
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h1F, 1'b0, 1'b1, 1'b1, 8'h00, EV_BAD_CHAR);
    // Non-hex byte right after \u.
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(CH_U, 1'b0, 1'b0, 1'b0, 8'h00, EV_BYTE);
    add_row(8'h47, 1'b0, 1'b1, 1'b1, 8'h00, EV_BAD_HEX);  // G
    // Text that ends on its opening quote.
    add_row(CH_QUOTE, 1'b1, 1'b1, 1'b1, 8'h00, EV_NO_QUOTE);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_text(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].has_res,
                dir_tab[i].ob, dir_tab[i].ev);
    end

    // Pause the sender until every result of the directed part has arrived.
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (want_q.size() != 0);

    while (rnd_sent < RandItems) begin
      build_string();
      foreach (str_q[i]) begin
        // A stretch of random traffic with no idling on either side.
        calm = (rnd_sent >= 120 && rnd_sent < 180);
        send_text(str_q[i].b, str_q[i].e, 1'b0, 1'b0, 8'h00, EV_BYTE);
        rnd_sent++;
      end
    end
    calm = 1'b0;

    // Drain, then keep watching for anything stray to show up.
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (want_q.size() != 0);
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("json_string_unescape_utf8_test OK");
    end else begin
      $display("json_string_unescape_utf8_test NOT OK");
    end
    $finish;
  end

endmodule
